// ===== rtl/core/wsd_pkg.sv =====
// shared types, codes and helpers for the websocket frame deframer
`default_nettype none
package wsd_pkg;

	localparam logic [2:0] ST_HDR0    = 3'd0;
	localparam logic [2:0] ST_HDR1    = 3'd1;
	localparam logic [2:0] ST_LENHI   = 3'd2;
	localparam logic [2:0] ST_LENLO   = 3'd3;
	localparam logic [2:0] ST_PAYLOAD = 3'd4;

	localparam logic [1:0] LINK_IDLE   = 2'd0;
	localparam logic [1:0] LINK_CONN   = 2'd1;
	localparam logic [1:0] LINK_CLOSED = 2'd2;
	localparam logic [1:0] LINK_ERROR  = 2'd3;

	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NOT_CONN   = 3'd1;
	localparam logic [2:0] ERR_FRAGMENTED = 3'd2;
	localparam logic [2:0] ERR_BAD_OPCODE = 3'd3;
	localparam logic [2:0] ERR_MASKED     = 3'd4;
	localparam logic [2:0] ERR_LEN64      = 3'd5;
	localparam logic [2:0] ERR_CTRL_BIG   = 3'd6;
	localparam logic [2:0] ERR_TOO_LARGE  = 3'd7;

	localparam logic       ACT_BYTE    = 1'b0;
	localparam logic       ACT_CONNECT = 1'b1;

	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [15:0] CTRL_MAX   = 16'd125;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [3:0] frame_opcode;
		logic       frame_done;
		logic [2:0] error_code;
		logic [1:0] link_state;
	} result_t;

	function automatic logic is_control(input logic [3:0] op);
		return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
	endfunction

	function automatic logic is_supported(input logic [3:0] op);
		return (op == OP_TEXT) || (op == OP_BINARY) || is_control(op);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wsd_decoder.sv =====
// frame parser state and single-word decode step
`default_nettype none
module wsd_decoder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             action,
	input  wire logic [7:0]       data_byte,
	input  wire logic [15:0]      max_payload,
	output wsd_pkg::result_t      result
);

	logic [2:0]  stage_q, stage_d;
	logic [3:0]  kind_q, kind_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [1:0]  link_q, link_d;

	logic [2:0]  err;
	logic        done;
	logic [3:0]  op;
	logic [7:0]  obyte;
	logic        valid;
	logic [15:0] new_len;
	logic        use_len;
	logic [15:0] cnt_inc;

	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		stage_d = stage_q;
		kind_d  = kind_q;
		lenhi_d = lenhi_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		link_d  = link_q;
		err     = wsd_pkg::ERR_NONE;
		done    = 1'b0;
		op      = wsd_pkg::OP_NONE;
		obyte   = 8'd0;
		valid   = 1'b0;
		new_len = 16'd0;
		use_len = 1'b0;

		if (action == wsd_pkg::ACT_CONNECT) begin
			stage_d = wsd_pkg::ST_HDR0;
			kind_d  = 4'd0;
			lenhi_d = 8'd0;
			len_d   = 16'd0;
			cnt_d   = 16'd0;
			link_d  = wsd_pkg::LINK_CONN;
		end else if (link_q != wsd_pkg::LINK_CONN) begin
			err = wsd_pkg::ERR_NOT_CONN;
		end else begin
			case (stage_q)
				wsd_pkg::ST_HDR1: begin
					if (data_byte[7]) begin
						err = wsd_pkg::ERR_MASKED;
					end else if (data_byte[6:0] < wsd_pkg::LEN_EXT16) begin
						new_len = {9'd0, data_byte[6:0]};
						use_len = 1'b1;
					end else if (data_byte[6:0] == wsd_pkg::LEN_EXT16) begin
						stage_d = wsd_pkg::ST_LENHI;
					end else begin
						err = wsd_pkg::ERR_LEN64;
					end
				end
				wsd_pkg::ST_LENHI: begin
					lenhi_d = data_byte;
					stage_d = wsd_pkg::ST_LENLO;
				end
				wsd_pkg::ST_LENLO: begin
					new_len = {lenhi_q, data_byte};
					use_len = 1'b1;
				end
				wsd_pkg::ST_PAYLOAD: begin
					obyte = data_byte;
					valid = 1'b1;
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q)
						done = 1'b1;
				end
				default: begin
					if (!data_byte[7]) begin
						err = wsd_pkg::ERR_FRAGMENTED;
					end else if (!wsd_pkg::is_supported(data_byte[3:0])) begin
						err = wsd_pkg::ERR_BAD_OPCODE;
					end else begin
						kind_d  = data_byte[3:0];
						stage_d = wsd_pkg::ST_HDR1;
					end
				end
			endcase

			if (use_len) begin
				if (wsd_pkg::is_control(kind_q) && (new_len > wsd_pkg::CTRL_MAX)) begin
					err = wsd_pkg::ERR_CTRL_BIG;
				end else if (new_len > max_payload) begin
					err = wsd_pkg::ERR_TOO_LARGE;
				end else begin
					len_d = new_len;
					cnt_d = 16'd0;
					if (new_len == 16'd0)
						done = 1'b1;
					else
						stage_d = wsd_pkg::ST_PAYLOAD;
				end
			end

			if (err == wsd_pkg::ERR_NONE)
				op = kind_d;
		end

		if (err != wsd_pkg::ERR_NONE) begin
			stage_d = wsd_pkg::ST_HDR0;
			kind_d  = 4'd0;
			lenhi_d = 8'd0;
			len_d   = 16'd0;
			cnt_d   = 16'd0;
			link_d  = wsd_pkg::LINK_ERROR;
			op      = wsd_pkg::OP_NONE;
			obyte   = 8'd0;
			valid   = 1'b0;
			done    = 1'b0;
		end else if (done) begin
			if (kind_q == wsd_pkg::OP_CLOSE)
				link_d = wsd_pkg::LINK_CLOSED;
			stage_d = wsd_pkg::ST_HDR0;
			kind_d  = 4'd0;
			lenhi_d = 8'd0;
			len_d   = 16'd0;
			cnt_d   = 16'd0;
		end

		result.out_byte     = obyte;
		result.byte_valid   = valid;
		result.frame_opcode = op;
		result.frame_done   = done;
		result.error_code   = err;
		result.link_state   = link_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= wsd_pkg::ST_HDR0;
			kind_q  <= 4'd0;
			lenhi_q <= 8'd0;
			len_q   <= 16'd0;
			cnt_q   <= 16'd0;
			link_q  <= wsd_pkg::LINK_IDLE;
		end else if (step) begin
			stage_q <= stage_d;
			kind_q  <= kind_d;
			lenhi_q <= lenhi_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			link_q  <= link_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wsd_out_stage.sv =====
// result register with valid/stall handshake towards the receiver
`default_nettype none
module wsd_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire wsd_pkg::result_t result_in,
	input  wire logic             stall,
	output logic                  free,
	output logic                  valid,
	output wsd_pkg::result_t      result_out
);

	logic             valid_s2;
	wsd_pkg::result_t result_s2;

	assign free       = !valid_s2 || !stall;
	assign valid      = valid_s2;
	assign result_out = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_s2 <= result_in;
	end

endmodule
`default_nettype wire

// ===== rtl/core/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer: input register, decoder and result register
//
// usage: received stream words enter on in_valid/in_stall with action and
// data_byte; action set means connect and clears the frame decoder.
// every accepted word gives exactly one result word on out_valid/out_stall
// carrying out_byte, byte_valid, frame_opcode, frame_done, error_code and
// link_state.
// the word waits in the input register, then the decode step loads the
// result register, which presents it to the receiver.
// throughput: one word per cycle while the receiver does not stall, set by
// the combinational decode step which updates the parser state as each
// word leaves the input register.
// a stall from the receiver holds the result register; the input register
// then holds its word and in_stall rises while both are full.
// max_payload is written on cfg_valid/cfg_ready, always ready, and resets
// to 1024; write it only while no words are in flight.
// reset clears the valid flags of both registers and puts the link in the idle state.
`default_nettype none
module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] max_payload,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic [3:0]       frame_opcode,
	output logic             frame_done,
	output logic [2:0]       error_code,
	output logic [1:0]       link_state
);

	logic [15:0]      max_payload_q;
	logic             valid_s1;
	logic             action_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             advance;
	logic             in_take;
	wsd_pkg::result_t dec_result;
	wsd_pkg::result_t out_result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wsd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= max_payload;
		end
	end

	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	wsd_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.action      (action_s1),
		.data_byte   (byte_s1),
		.max_payload (max_payload_q),
		.result      (dec_result)
	);

	wsd_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.result_in  (dec_result),
		.stall      (out_stall),
		.free       (out_free),
		.valid      (out_valid),
		.result_out (out_result)
	);

	assign out_byte     = out_result.out_byte;
	assign byte_valid   = out_result.byte_valid;
	assign frame_opcode = out_result.frame_opcode;
	assign frame_done   = out_result.frame_done;
	assign error_code   = out_result.error_code;
	assign link_state   = out_result.link_state;

`ifndef SYNTHESIS
	a_err_sets_error_link: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (error_code != wsd_pkg::ERR_NONE))
			|-> (link_state == wsd_pkg::LINK_ERROR) && !byte_valid && !frame_done
			&& (frame_opcode == wsd_pkg::OP_NONE))
		else $error("error result without error link state or with payload");

	a_byte_needs_conn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid)
			|-> (link_state == wsd_pkg::LINK_CONN) || (link_state == wsd_pkg::LINK_CLOSED))
		else $error("payload word while link not connected");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while pipeline has room");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_result)))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_websocket_frame_deframer.sv =====
// self-checking testbench for the websocket frame deframer with a scoreboard class
`default_nettype none
module tb_websocket_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 1150;
	localparam int PHASES       = 6;
	localparam int DRAIN_CYCLES = 8;

	class deframer_scoreboard;
		logic [15:0]      limit;
		logic [2:0]       stage;
		logic [3:0]       kind;
		logic [7:0]       len_hi;
		logic [15:0]      plen;
		logic [15:0]      pcount;
		logic [1:0]       link;
		wsd_pkg::result_t due_results[$];
		int               errors;

		function new();
			limit = wsd_pkg::MAX_PAYLOAD_RESET;
			drop_frame();
			link = wsd_pkg::LINK_IDLE;
			errors = 0;
		endfunction

		function void drop_frame();
			stage = wsd_pkg::ST_HDR0;
			kind = wsd_pkg::OP_NONE;
			len_hi = '0;
			plen = '0;
			pcount = '0;
		endfunction

		function logic [2:0] open_payload(input logic [15:0] len, inout bit done);
			if ((kind == wsd_pkg::OP_CLOSE || kind == wsd_pkg::OP_PING ||
				kind == wsd_pkg::OP_PONG) && len > wsd_pkg::CTRL_MAX)
				return wsd_pkg::ERR_CTRL_BIG;
			if (len > limit)
				return wsd_pkg::ERR_TOO_LARGE;
			plen = len;
			pcount = '0;
			if (len == 16'd0)
				done = 1'b1;
			else
				stage = wsd_pkg::ST_PAYLOAD;
			return wsd_pkg::ERR_NONE;
		endfunction

		function void note_word(input logic act, input logic [7:0] b);
			wsd_pkg::result_t r;
			bit               done;
			logic [2:0]       err;
			logic [3:0]       op;
			r = '0;
			done = 1'b0;
			err = wsd_pkg::ERR_NONE;
			op = b[3:0];
			if (act == wsd_pkg::ACT_CONNECT) begin
				drop_frame();
				link = wsd_pkg::LINK_CONN;
			end else if (link != wsd_pkg::LINK_CONN) begin
				err = wsd_pkg::ERR_NOT_CONN;
			end else begin
				case (stage)
					wsd_pkg::ST_HDR1: begin
						if (b[7])
							err = wsd_pkg::ERR_MASKED;
						else if (b[6:0] < wsd_pkg::LEN_EXT16)
							err = open_payload({9'd0, b[6:0]}, done);
						else if (b[6:0] == wsd_pkg::LEN_EXT16)
							stage = wsd_pkg::ST_LENHI;
						else
							err = wsd_pkg::ERR_LEN64;
					end
					wsd_pkg::ST_LENHI: begin
						len_hi = b;
						stage = wsd_pkg::ST_LENLO;
					end
					wsd_pkg::ST_LENLO: begin
						err = open_payload({len_hi, b}, done);
					end
					wsd_pkg::ST_PAYLOAD: begin
						r.out_byte = b;
						r.byte_valid = 1'b1;
						pcount = pcount + 16'd1;
						if (pcount >= plen)
							done = 1'b1;
					end
					default: begin
						if (!b[7])
							err = wsd_pkg::ERR_FRAGMENTED;
						else if (!(op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY ||
							op == wsd_pkg::OP_CLOSE || op == wsd_pkg::OP_PING ||
							op == wsd_pkg::OP_PONG))
							err = wsd_pkg::ERR_BAD_OPCODE;
						else begin
							kind = op;
							stage = wsd_pkg::ST_HDR1;
						end
					end
				endcase
				if (err == wsd_pkg::ERR_NONE)
					r.frame_opcode = kind;
			end
			if (err != wsd_pkg::ERR_NONE) begin
				drop_frame();
				link = wsd_pkg::LINK_ERROR;
				r.out_byte = '0;
				r.byte_valid = 1'b0;
				r.frame_opcode = wsd_pkg::OP_NONE;
				done = 1'b0;
			end else if (done) begin
				if (kind == wsd_pkg::OP_CLOSE)
					link = wsd_pkg::LINK_CLOSED;
				drop_frame();
			end
			r.frame_done = done;
			r.error_code = err;
			r.link_state = link;
			due_results.push_back(r);
		endfunction

		function void match_field(input string name, input int unsigned want,
			input int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(input wsd_pkg::result_t got);
			wsd_pkg::result_t want;
			if (due_results.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			match_field("out_byte", want.out_byte, got.out_byte);
			match_field("byte_valid", want.byte_valid, got.byte_valid);
			match_field("frame_opcode", want.frame_opcode, got.frame_opcode);
			match_field("frame_done", want.frame_done, got.frame_done);
			match_field("error_code", want.error_code, got.error_code);
			match_field("link_state", want.link_state, got.link_state);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = wsd_pkg::MAX_PAYLOAD_RESET;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = wsd_pkg::ACT_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [3:0]  frame_opcode;
	logic        frame_done;
	logic [2:0]  error_code;
	logic [1:0]  link_state;

	deframer_scoreboard sb = new();
	int words_sent = 0;
	int burst_left = 0;
	int cycles = 0;
	int stall_left = 0;
	int stall_pct = 0;

	websocket_frame_deframer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.max_payload (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.frame_opcode(frame_opcode),
		.frame_done  (frame_done),
		.error_code  (error_code),
		.link_state  (link_state)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_websocket_frame_deframer: errors");
			$finish;
		end
	end

	// receiver: stall rate changes from one stretch to the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_word({out_byte, byte_valid, frame_opcode, frame_done,
					error_code, link_state});
			if (stall_left == 0) begin
				stall_left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else begin
				stall_left--;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic put_word(input logic act, input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(act, b);
		burst_left--;
		words_sent++;
	endtask

	task automatic connect();
		put_word(wsd_pkg::ACT_CONNECT, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_bytes(input logic [7:0] seq[$]);
		foreach (seq[i])
			put_word(wsd_pkg::ACT_BYTE, seq[i]);
	endtask

	// cut >= 0 drops the frame with a connect after that many bytes
	task automatic send_frame(input logic [3:0] op, input int len, input bit ext,
		input int cut);
		logic [7:0]  seq[$];
		logic [15:0] l16;
		l16 = 16'(len);
		seq.push_back({1'b1, 3'($urandom_range(0, 7)), op});
		if (ext || len > 125) begin
			seq.push_back({1'b0, wsd_pkg::LEN_EXT16});
			seq.push_back(l16[15:8]);
			seq.push_back(l16[7:0]);
		end else begin
			seq.push_back(l16[7:0]);
		end
		repeat (len) seq.push_back(8'($urandom_range(0, 255)));
		foreach (seq[i]) begin
			if (i == cut) begin
				connect();
				return;
			end
			put_word(wsd_pkg::ACT_BYTE, seq[i]);
		end
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.limit = value;
	endtask

	task automatic run_phase(input logic [15:0] value, input int quota);
		int         start;
		int         pick;
		int         len;
		int         cut;
		logic [3:0] op;
		write_limit(value);
		start = words_sent;
		while (words_sent - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (sb.link != wsd_pkg::LINK_CONN)
					connect();
				case ($urandom_range(0, 9))
					0, 1, 2, 9: op = wsd_pkg::OP_TEXT;
					3, 4, 5: op = wsd_pkg::OP_BINARY;
					6: op = wsd_pkg::OP_PING;
					7: op = wsd_pkg::OP_PONG;
					default: op = wsd_pkg::OP_CLOSE;
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 60)
					len = $urandom_range(0, 16);
				else if (pick < 85)
					len = $urandom_range(0, 130);
				else if (pick < 97)
					len = $urandom_range(126, 400);
				else
					len = $urandom_range(1000, 1100);
				// keep the phase close to its share of words
				if (len > quota - (words_sent - start))
					len = quota - (words_sent - start);
				cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len + 3) : -1;
				send_frame(op, len, $urandom_range(0, 4) == 0, cut);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4))
					put_word(wsd_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
			end else begin
				connect();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte before any connect, then header error cases one by one
		send_bytes('{8'h81});
		connect();
		send_bytes('{8'h03});
		connect();
		send_bytes('{8'h8f});
		connect();
		send_bytes('{8'h81, 8'hff});
		connect();
		send_bytes('{8'h82, 8'h7f});
		connect();
		send_bytes('{8'h89, 8'h7e, 8'h00, 8'h7e});
		connect();
		send_bytes('{8'h82, 8'h7e, 8'hff, 8'hff});
		connect();
		// empty frame via extended length, reserved bits set
		send_bytes('{8'hf1, 8'h7e, 8'h00, 8'h00});
		send_bytes('{8'h82, 8'h02, 8'h00, 8'hff});
		send_bytes('{8'h89, 8'h03, 8'ha5});
		connect();
		send_bytes('{8'h88, 8'h00, 8'h00});

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: run_phase(16'd0, RANDOM_WORDS / PHASES);
				1: run_phase(16'hffff, RANDOM_WORDS / PHASES);
				2: run_phase(16'($urandom_range(1, 40)), RANDOM_WORDS / PHASES);
				3: run_phase(16'($urandom_range(0, 65535)), RANDOM_WORDS / PHASES);
				4: run_phase(wsd_pkg::CTRL_MAX, RANDOM_WORDS / PHASES);
				default: run_phase(wsd_pkg::MAX_PAYLOAD_RESET, RANDOM_WORDS / PHASES);
			endcase
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_websocket_frame_deframer: clean");
		else
			$display("tb_websocket_frame_deframer: errors");
		$finish;
	end

endmodule
`default_nettype wire
